// ===== rtl/core/ira_pkg.sv =====
// ----------------------------------------------------------------------------
// ira_pkg: shared constants and types for the interval room allocator
// Sizes, cell bus and control state codes.
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int unsigned MaxCustomers = 64;
  localparam int unsigned TimeBits     = 30;
  localparam int unsigned IdxW         = $clog2(MaxCustomers);
  localparam int unsigned CntW         = $clog2(MaxCustomers + 1);

  // Booking as it travels along the cell chain
  typedef struct packed {
    logic [TimeBits-1:0] arr;
    logic [TimeBits-1:0] dep;
    logic [IdxW-1:0]     idx;
  } bk_t;

  // Slot of the room store: last departure and room number
  typedef struct packed {
    logic [TimeBits-1:0] dep;
    logic [CntW-1:0]     room;
  } slot_t;

  typedef enum logic [4:0] {
    StLoad  = 5'b00001,
    StSort  = 5'b00010,
    StAlloc = 5'b00100,
    StPick  = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  // Ordering of two bookings: arrival, then departure, then load index
  function automatic logic bk_before(bk_t a, bk_t b);
    if (a.arr != b.arr) return a.arr < b.arr;
    if (a.dep != b.dep) return a.dep < b.dep;
    return a.idx < b.idx;
  endfunction

  // Slot a wins over slot b: earlier departure, on a tie higher room
  function automatic logic slot_wins(slot_t a, slot_t b);
    if (a.dep != b.dep) return a.dep < b.dep;
    return a.room > b.room;
  endfunction

endpackage

// ===== rtl/core/ira_sort_cell.sv =====
// ----------------------------------------------------------------------------
// ira_sort_cell: one cell of the insertion sort chain
// Keeps the smaller booking and passes the larger one on; in shift mode it hands its content on.
// ----------------------------------------------------------------------------
module ira_sort_cell import ira_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clr_i,     // empty the cell
  input  logic shift_i,   // shift mode: hand content to the right neighbour
  input  logic in_vld_i,
  input  bk_t  in_bk_i,
  output logic out_vld_o,
  output bk_t  out_bk_o
);

  logic vld_q, vld_d, ovld_q, ovld_d;
  bk_t  bk_q, bk_d, obk_q, obk_d;

  always_comb begin
    vld_d  = vld_q;
    bk_d   = bk_q;
    ovld_d = 1'b0;
    obk_d  = in_bk_i;
    if (clr_i) begin
      vld_d = 1'b0;
    end else if (shift_i) begin
      ovld_d = vld_q;
      obk_d  = bk_q;
      vld_d  = in_vld_i;
      bk_d   = in_bk_i;
    end else if (in_vld_i) begin
      if (!vld_q) begin
        vld_d = 1'b1;
        bk_d  = in_bk_i;
      end else if (bk_before(in_bk_i, bk_q)) begin
        bk_d   = in_bk_i;
        ovld_d = 1'b1;
        obk_d  = bk_q;
      end else begin
        ovld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bk_q  <= bk_d;
    obk_q <= obk_d;
  end

  assign out_vld_o = shift_i ? vld_q : ovld_q;
  assign out_bk_o  = shift_i ? bk_q : obk_q;

endmodule

// ===== rtl/core/ira_ram.sv =====
// ----------------------------------------------------------------------------
// ira_ram: generic single-port-write, one-read RAM with registered read
// ----------------------------------------------------------------------------
module ira_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/interval_room_allocator_top.sv =====
// ----------------------------------------------------------------------------
// interval_room_allocator_top: greedy interval partitioning of bookings
// Loads bookings, sorts them in a cell chain, assigns rooms, reports rooms.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one booking request per beat, tdata holds the
//   arrival in the low bits and the departure above it, tlast marks the final
//   booking of a set. Loading takes one request per cycle. Bookings beyond 64
//   are dropped and flagged.
//   Each booking is also inserted into a chain of 64 sort cells, which orders
//   them by arrival, departure and load index as they arrive.
//   After the final request the chain settles and is then shifted out. For
//   each sorted booking, a scan over the room slots opened so far, one slot
//   per cycle, finds the earliest departure.
//   Results leave on m_axis_*: one per stored booking in load order, each
//   after its room is read back, tlast on the final one.
//   A stalled receiver holds the output register; no request is taken until
//   the last report of a set is in the output register. Reset empties the
//   chain and clears the counters.
// ----------------------------------------------------------------------------
module interval_room_allocator_top import ira_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [29:0] arrival_time, [59:30] departure_time
  input  logic        s_axis_tlast,   // final_booking
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] booking_index, [12:6] room_number,
                                      // [19:13] rooms_needed, [20] capacity_overflow
  output logic        m_axis_tlast    // last_result
);

  localparam int unsigned N = MaxCustomers;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;      // bookings stored
  logic [CntW-1:0] k_q, k_d;          // general step counter
  logic [CntW-1:0] hsz_q, hsz_d;      // slots in use
  logic [CntW-1:0] scan_q, scan_d;
  logic            ovf_q, ovf_d;
  slot_t           best_q, best_d;
  logic [IdxW-1:0] besti_q, besti_d;
  bk_t             cur_q, cur_d;
  logic            ov_q, ov_d;        // output valid
  logic [23:0]     od_q, od_d;
  logic            ol_q, ol_d;

  // ---------------- sort chain ----------------
  logic            clr, shift, in_vld;
  bk_t             in_bk;
  logic [N:0]      cv;
  bk_t             cb [N+1];

  assign cv[0] = in_vld;
  assign cb[0] = in_bk;

  for (genvar g = 0; g < N; g++) begin : g_cell
    ira_sort_cell u_cell (
      .clk_i, .rst_ni,
      .clr_i(clr), .shift_i(shift),
      .in_vld_i(cv[g]), .in_bk_i(cb[g]),
      .out_vld_o(cv[g+1]), .out_bk_o(cb[g+1])
    );
  end

  // Shift mode moves every cell one place towards the chain end, so shift
  // cycle k yields the content of cell N-1-k, i.e. sorted rank N-1-k.
  // Valid entries are captured into a RAM at their rank and replayed.
  logic            sw_we;
  logic [IdxW-1:0] sw_addr, sr_addr;
  bk_t             sr_data;

  ira_ram #(.Width($bits(bk_t)), .Depth(N)) u_sorted (
    .clk_i, .we_i(sw_we), .waddr_i(sw_addr), .wdata_i(cb[N]),
    .raddr_i(sr_addr), .rdata_o(sr_data)
  );

  // room of booking
  logic            rw_we;
  logic [IdxW-1:0] rw_addr, rr_addr;
  logic [CntW-1:0] rw_data, rr_data;

  ira_ram #(.Width(CntW), .Depth(N)) u_rooms (
    .clk_i, .we_i(rw_we), .waddr_i(rw_addr), .wdata_i(rw_data),
    .raddr_i(rr_addr), .rdata_o(rr_data)
  );

  // room slots: one written per pick, scanned one per cycle
  logic            sl_we;
  logic [IdxW-1:0] sl_waddr, sl_raddr;
  slot_t           sl_wdata, sl_rdata;

  ira_ram #(.Width($bits(slot_t)), .Depth(N)) u_slots (
    .clk_i, .we_i(sl_we), .waddr_i(sl_waddr), .wdata_i(sl_wdata),
    .raddr_i(sl_raddr), .rdata_o(sl_rdata)
  );

  wire s_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StLoad);

  logic [CntW-1:0] rank;
  assign rank = CntW'(N - 1) - k_q;

  // earliest slot frees up before this booking arrives
  logic reuse;
  assign reuse = (hsz_q != '0) && (best_q.dep < cur_q.arr);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    hsz_d   = hsz_q;
    scan_d  = scan_q;
    ovf_d   = ovf_q;
    best_d  = best_q;
    besti_d = besti_q;
    cur_d   = cur_q;
    ov_d    = ov_q;
    od_d    = od_q;
    ol_d    = ol_q;
    clr     = 1'b0;
    shift   = 1'b0;
    in_vld  = 1'b0;
    in_bk.arr = s_axis_tdata[TimeBits-1:0];
    in_bk.dep = s_axis_tdata[30+TimeBits-1:30];
    in_bk.idx = cnt_q[IdxW-1:0];
    sw_we   = 1'b0;
    sw_addr = rank[IdxW-1:0];
    sr_addr = k_q[IdxW-1:0];
    rw_we   = 1'b0;
    rw_addr = cur_q.idx;
    rw_data = '0;
    rr_addr = k_q[IdxW-1:0];
    sl_we   = 1'b0;
    sl_waddr = reuse ? besti_q : hsz_q[IdxW-1:0];
    sl_wdata.dep  = cur_q.dep;
    sl_wdata.room = reuse ? best_q.room : hsz_q + 1'b1;
    sl_raddr = scan_q[IdxW-1:0];
    if (ov_q && m_axis_tready) ov_d = 1'b0;

    case (state_q)
      StLoad: begin
        if (s_acc) begin
          if (cnt_q < CntW'(N)) begin
            in_vld = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = StSort;
            k_d     = '0;
          end
        end
      end
      StSort: begin
        // k counts 0..N while the ripple settles
        k_d = k_q + 1'b1;
        if (k_q == CntW'(N)) begin
          state_d = StAlloc;
          k_d     = '0;
        end
      end
      StAlloc: begin
        // shift phase, k counts 0..N-1
        shift = 1'b1;
        sw_we = cv[N];
        k_d   = k_q + 1'b1;
        if (k_q == CntW'(N - 1)) begin
          state_d = StPick;
          k_d     = '0;
          hsz_d   = '0;
          scan_d  = '0;
          clr     = 1'b1;
        end
      end
      StPick: begin
        // k: sorted rank; scan 0: issue reads; 1: booking and slot 0 ready;
        // 2..: slot scan-1 ready; last: place the booking
        if (k_q == cnt_q) begin
          state_d = StEmit;
          k_d     = '0;
          scan_d  = '0;
        end else if (scan_q == '0) begin
          scan_d = CntW'(1);
        end else if (scan_q == CntW'(1)) begin
          cur_d   = sr_data;
          best_d  = sl_rdata;
          besti_d = '0;
          scan_d  = CntW'(2);
        end else if (scan_q < hsz_q + 1'b1) begin
          if (slot_wins(sl_rdata, best_q)) begin
            best_d  = sl_rdata;
            besti_d = scan_q[IdxW-1:0] - 1'b1;
          end
          scan_d = scan_q + 1'b1;
        end else begin
          rw_we = 1'b1;
          sl_we = 1'b1;
          if (reuse) begin
            rw_data = best_q.room;
          end else begin
            rw_data = hsz_q + 1'b1;
            hsz_d   = hsz_q + 1'b1;
          end
          k_d    = k_q + 1'b1;
          scan_d = '0;
        end
      end
      StEmit: begin
        // scan 0: read issued; 1: data ready, load output
        if (scan_q == '0) begin
          scan_d = CntW'(1);
        end else if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          od_d = {3'b0, ovf_q, hsz_q, rr_data, k_q[IdxW-1:0]};
          ol_d = (k_q + 1'b1 == cnt_q);
          k_d    = k_q + 1'b1;
          scan_d = '0;
          if (k_q + 1'b1 == cnt_q) begin
            state_d = StLoad;
            cnt_d   = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    besti_q <= besti_d;
    cur_q   <= cur_d;
    od_q    <= od_d;
    ol_q    <= ol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      k_q     <= '0;
      hsz_q   <= '0;
      scan_q  <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      hsz_q   <= hsz_d;
      scan_q  <= scan_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

  // Assertions
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(N)) else $error("booking count beyond capacity");
  a_hsz_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPick || state_q == StEmit) |-> hsz_q <= cnt_q)
    else $error("more rooms than bookings");
  a_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StLoad |-> !s_axis_tready)
    else $error("ready outside load");

endmodule
